FILE: hdl/u16550_pkg.sv
package u16550_pkg;

  localparam int RX_FIFO_DEPTH = 16;
  localparam int RX_IDX_W = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
  localparam int RX_CNT_W = $clog2(RX_FIFO_DEPTH + 1);
  localparam int RX_LVL_W = (RX_CNT_W > 4) ? RX_CNT_W : 4;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LINE  = 2'd2;

  localparam logic [2:0] REG_RBR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  localparam int LCR_DLAB_BIT     = 7;
  localparam int MCR_OUT2_BIT     = 3;
  localparam int MCR_LOOP_BIT     = 4;
  localparam int FCR_ENABLE_BIT   = 0;
  localparam int FCR_RX_CLEAR_BIT = 1;

  localparam logic [7:0] IIR_RX_DATA   = 8'h04;
  localparam logic [7:0] IIR_NO_INT    = 8'h01;
  localparam logic [7:0] IIR_FIFO_BITS = 8'hC0;
  localparam logic [7:0] LSR_TX_EMPTY  = 8'h60;

  localparam int TRIG_LVL_0 = 1;
  localparam int TRIG_LVL_1 = 4;
  localparam int TRIG_LVL_2 = 8;
  localparam int TRIG_LVL_3 = 14;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] offset;
    logic [7:0] bus_wdata;
    logic [7:0] line_byte;
  } u16550_in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } u16550_out_t;

  // Receive trigger level, saturated at the current capacity.
  function automatic logic [RX_LVL_W-1:0] rx_trigger(input logic       fifo_on,
                                                     input logic [1:0] sel);
    logic [RX_LVL_W-1:0] lvl;
    logic [RX_LVL_W-1:0] cap;
    case (sel)
      2'd0:    lvl = RX_LVL_W'(TRIG_LVL_0);
      2'd1:    lvl = RX_LVL_W'(TRIG_LVL_1);
      2'd2:    lvl = RX_LVL_W'(TRIG_LVL_2);
      default: lvl = RX_LVL_W'(TRIG_LVL_3);
    endcase
    if (!fifo_on) begin
      lvl = RX_LVL_W'(1);
    end
    cap = fifo_on ? RX_LVL_W'(RX_FIFO_DEPTH) : RX_LVL_W'(1);
    return (lvl > cap) ? cap : lvl;
  endfunction

endpackage

FILE: hdl/uart_16550_register_model.sv
// Channel  Handshake             Payload
// in       in_valid / in_stall   in_data  (cmd, offset, bus_wdata, line_byte)
// out      out_valid / out_stall out_data (rdata, irq, tx_valid, tx_byte)
//
// One request is accepted per cycle while in_stall is low.
// The receive FIFO sits in a one-port-read synchronous RAM, so an RBR read
// gets its data during the second stage, ahead of the output register.
// Reset clears the control registers and empties the FIFO; no clearing pass is needed.
// A stalled output holds its result while one more request is taken.
module uart_16550_register_model
  import u16550_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  u16550_in_t  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output u16550_out_t out_data
);

  localparam int SUM_W = RX_CNT_W + 1;

  logic [3:0]          ier_r, ier_nxt;
  logic [7:0]          lcr_r, lcr_nxt;
  logic [4:0]          mcr_r, mcr_nxt;
  logic [7:0]          dll_r, dll_nxt;
  logic [7:0]          dlm_r, dlm_nxt;
  logic                fifo_on_r, fifo_on_nxt;
  logic [1:0]          trig_sel_r, trig_sel_nxt;
  logic [7:0]          scr_r, scr_nxt;
  logic [RX_IDX_W-1:0] rx_head_r, rx_head_nxt;
  logic [RX_CNT_W-1:0] rx_count_r, rx_count_nxt;
  logic                overrun_r, overrun_nxt;

  logic                s1_valid_r;
  logic                s1_pop_r;
  u16550_out_t         s1_res_r;
  logic                out_valid_r;
  u16550_out_t         out_data_r;

  logic                accept;
  logic                out_free;
  logic                dlab;
  logic                loopback;
  logic                pending;
  logic [RX_CNT_W-1:0] cap;
  logic                push_req;
  logic [7:0]          push_byte;
  logic                push;
  logic                pop;
  logic                clear;
  logic [SUM_W-1:0]    wsum;
  logic [SUM_W-1:0]    wsum_wrap;
  logic [RX_IDX_W-1:0] wr_addr;
  logic [7:0]          ram_q;
  u16550_out_t         res;
  u16550_out_t         s1_out;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  assign dlab     = lcr_r[LCR_DLAB_BIT];
  assign loopback = mcr_r[MCR_LOOP_BIT];
  assign cap      = fifo_on_r ? RX_CNT_W'(RX_FIFO_DEPTH) : RX_CNT_W'(1);
  assign pending  = ier_r[0] &&
                    (RX_LVL_W'(rx_count_r) >= rx_trigger(fifo_on_r, trig_sel_r));

  assign wsum      = SUM_W'(rx_head_r) + SUM_W'(rx_count_r);
  assign wsum_wrap = (wsum >= SUM_W'(RX_FIFO_DEPTH)) ? wsum - SUM_W'(RX_FIFO_DEPTH) : wsum;
  assign wr_addr   = wsum_wrap[RX_IDX_W-1:0];

  always_comb begin
    ier_nxt      = ier_r;
    lcr_nxt      = lcr_r;
    mcr_nxt      = mcr_r;
    dll_nxt      = dll_r;
    dlm_nxt      = dlm_r;
    fifo_on_nxt  = fifo_on_r;
    trig_sel_nxt = trig_sel_r;
    scr_nxt      = scr_r;
    rx_head_nxt  = rx_head_r;
    rx_count_nxt = rx_count_r;
    overrun_nxt  = overrun_r;
    push_req     = 1'b0;
    push_byte    = in_data.line_byte;
    push         = 1'b0;
    pop          = 1'b0;
    clear        = 1'b0;
    res          = '0;
    if (accept) begin
      case (in_data.cmd)
        CMD_READ: begin
          case (in_data.offset)
            REG_RBR: begin
              if (dlab) begin
                res.rdata = dll_r;
              end else if (rx_count_r != '0) begin
                pop = 1'b1;
              end
            end
            REG_IER: res.rdata = dlab ? dlm_r : {4'b0000, ier_r};
            REG_IIR: res.rdata = (pending ? IIR_RX_DATA : IIR_NO_INT) |
                                 (fifo_on_r ? IIR_FIFO_BITS : 8'h00);
            REG_LCR: res.rdata = lcr_r;
            REG_MCR: res.rdata = {3'b000, mcr_r};
            REG_LSR: begin
              res.rdata   = LSR_TX_EMPTY | {6'b000000, overrun_r, rx_count_r != '0};
              overrun_nxt = 1'b0;
            end
            REG_MSR: res.rdata = 8'h00;
            default: res.rdata = scr_r;
          endcase
        end
        CMD_WRITE: begin
          case (in_data.offset)
            REG_RBR: begin
              if (dlab) begin
                dll_nxt = in_data.bus_wdata;
              end else if (loopback) begin
                push_req  = 1'b1;
                push_byte = in_data.bus_wdata;
              end else begin
                res.tx_valid = 1'b1;
                res.tx_byte  = in_data.bus_wdata;
              end
            end
            REG_IER: begin
              if (dlab) begin
                dlm_nxt = in_data.bus_wdata;
              end else begin
                ier_nxt = in_data.bus_wdata[3:0];
              end
            end
            REG_IIR: begin
              clear = (in_data.bus_wdata[FCR_ENABLE_BIT] != fifo_on_r) ||
                      in_data.bus_wdata[FCR_RX_CLEAR_BIT];
              fifo_on_nxt  = in_data.bus_wdata[FCR_ENABLE_BIT];
              trig_sel_nxt = in_data.bus_wdata[7:6];
            end
            REG_LCR: lcr_nxt = in_data.bus_wdata;
            REG_MCR: mcr_nxt = in_data.bus_wdata[4:0];
            REG_SCR: scr_nxt = in_data.bus_wdata;
            default: ;
          endcase
        end
        CMD_LINE: push_req = !loopback;
        default: ;
      endcase
    end
    if (push_req) begin
      if (rx_count_r >= cap) begin
        overrun_nxt = 1'b1;
      end else begin
        push         = 1'b1;
        rx_count_nxt = rx_count_r + RX_CNT_W'(1);
      end
    end
    if (pop) begin
      rx_head_nxt  = (rx_head_r == RX_IDX_W'(RX_FIFO_DEPTH - 1)) ? '0 :
                     rx_head_r + RX_IDX_W'(1);
      rx_count_nxt = rx_count_r - RX_CNT_W'(1);
    end
    if (clear) begin
      rx_head_nxt  = '0;
      rx_count_nxt = '0;
    end
    res.irq = ier_nxt[0] && mcr_nxt[MCR_OUT2_BIT] &&
              (RX_LVL_W'(rx_count_nxt) >= rx_trigger(fifo_on_nxt, trig_sel_nxt));
  end

  always_comb begin
    s1_out = s1_res_r;
    if (s1_pop_r) begin
      s1_out.rdata = ram_q;
    end
  end

  u16550_ram #(
    .WIDTH(8),
    .DEPTH(RX_FIFO_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_addr),
    .wdata (push_byte),
    .re    (pop),
    .raddr (rx_head_r),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ier_r      <= '0;
      lcr_r      <= '0;
      mcr_r      <= '0;
      dll_r      <= '0;
      dlm_r      <= '0;
      fifo_on_r  <= 1'b0;
      trig_sel_r <= '0;
      scr_r      <= '0;
      rx_head_r  <= '0;
      rx_count_r <= '0;
      overrun_r  <= 1'b0;
    end else begin
      ier_r      <= ier_nxt;
      lcr_r      <= lcr_nxt;
      mcr_r      <= mcr_nxt;
      dll_r      <= dll_nxt;
      dlm_r      <= dlm_nxt;
      fifo_on_r  <= fifo_on_nxt;
      trig_sel_r <= trig_sel_nxt;
      scr_r      <= scr_nxt;
      rx_head_r  <= rx_head_nxt;
      rx_count_r <= rx_count_nxt;
      overrun_r  <= overrun_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop_r <= pop;
      s1_res_r <= res;
    end
    if (out_free) begin
      out_data_r <= s1_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rx_count_r <= cap)
    else $error("receive count exceeds capacity");

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    accept && s1_valid_r |-> out_free)
    else $error("second stage overwritten while held");

  a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_pop_r && !out_free |=> $stable(ram_q))
    else $error("pending RBR data changed in the RAM output");

  a_lsr_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.cmd == CMD_READ && in_data.offset == REG_LSR |=> !overrun_r)
    else $error("overrun not cleared by LSR read");
`endif

endmodule

FILE: hdl/u16550_ram.sv
module u16550_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import u16550_pkg::*;
;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic [2:0] REG_THR = REG_RBR;
  localparam logic [2:0] REG_DLL = REG_RBR;
  localparam logic [2:0] REG_DLM = REG_IER;
  localparam logic [2:0] REG_FCR = REG_IIR;
  localparam int RANDOM_REQUESTS = 1400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} traffic_t;

  class uart_result_board;
    bit [3:0] ier;
    bit [7:0] lcr;
    bit [4:0] mcr;
    bit [7:0] dll;
    bit [7:0] dlm;
    bit       fifo_en;
    bit [1:0] trig_sel;
    bit [7:0] scr;
    bit [7:0] rx_mem [RX_FIFO_DEPTH];
    int       rx_head;
    int       rx_count;
    bit       overrun;
    u16550_out_t expected_responses[$];
    int       failures;

    function new();
      ier = '0;
      lcr = '0;
      mcr = '0;
      dll = '0;
      dlm = '0;
      fifo_en = 1'b0;
      trig_sel = '0;
      scr = '0;
      rx_head = 0;
      rx_count = 0;
      overrun = 1'b0;
      failures = 0;
    endfunction

    function int rx_capacity();
      return fifo_en ? RX_FIFO_DEPTH : 1;
    endfunction

    function bit rx_data_pending();
      int lvl;
      case (trig_sel)
        2'd0: lvl = TRIG_LVL_0;
        2'd1: lvl = TRIG_LVL_1;
        2'd2: lvl = TRIG_LVL_2;
        default: lvl = TRIG_LVL_3;
      endcase
      if (!fifo_en) begin
        lvl = 1;
      end
      if (lvl > rx_capacity()) begin
        lvl = rx_capacity();
      end
      return ier[0] && (rx_count >= lvl);
    endfunction

    function void rx_enqueue(bit [7:0] b);
      if (rx_count >= rx_capacity()) begin
        overrun = 1'b1;
      end else begin
        rx_mem[(rx_head + rx_count) % RX_FIFO_DEPTH] = b;
        rx_count++;
      end
    endfunction

    function void note_request(u16550_in_t req);
      u16550_out_t rsp;
      bit dlab;
      bit [7:0] d;
      rsp = '0;
      dlab = lcr[LCR_DLAB_BIT];
      d = req.bus_wdata;
      case (req.cmd)
        CMD_READ: begin
          case (req.offset)
            REG_RBR: begin
              if (dlab) begin
                rsp.rdata = dll;
              end else if (rx_count != 0) begin
                rsp.rdata = rx_mem[rx_head];
                rx_head = (rx_head + 1) % RX_FIFO_DEPTH;
                rx_count--;
              end
            end
            REG_IER: rsp.rdata = dlab ? dlm : {4'b0000, ier};
            REG_IIR: begin
              rsp.rdata = rx_data_pending() ? IIR_RX_DATA : IIR_NO_INT;
              if (fifo_en) begin
                rsp.rdata = rsp.rdata | IIR_FIFO_BITS;
              end
            end
            REG_LCR: rsp.rdata = lcr;
            REG_MCR: rsp.rdata = {3'b000, mcr};
            REG_LSR: begin
              rsp.rdata = LSR_TX_EMPTY | {6'b0, overrun, rx_count != 0};
              overrun = 1'b0;
            end
            REG_MSR: rsp.rdata = '0;
            default: rsp.rdata = scr;
          endcase
        end
        CMD_WRITE: begin
          case (req.offset)
            REG_THR: begin
              if (dlab) begin
                dll = d;
              end else if (mcr[MCR_LOOP_BIT]) begin
                rx_enqueue(d);
              end else begin
                rsp.tx_valid = 1'b1;
                rsp.tx_byte = d;
              end
            end
            REG_IER: begin
              if (dlab) begin
                dlm = d;
              end else begin
                ier = d[3:0];
              end
            end
            REG_FCR: begin
              if (d[FCR_ENABLE_BIT] != fifo_en || d[FCR_RX_CLEAR_BIT]) begin
                rx_head = 0;
                rx_count = 0;
              end
              fifo_en = d[FCR_ENABLE_BIT];
              trig_sel = d[7:6];
            end
            REG_LCR: lcr = d;
            REG_MCR: mcr = d[4:0];
            REG_SCR: scr = d;
            default: ;
          endcase
        end
        CMD_LINE: begin
          if (!mcr[MCR_LOOP_BIT]) begin
            rx_enqueue(req.line_byte);
          end
        end
        default: ;
      endcase
      rsp.irq = rx_data_pending() && mcr[MCR_OUT2_BIT];
      expected_responses.push_back(rsp);
    endfunction

    function void check_result(u16550_out_t got);
      u16550_out_t exp;
      if (expected_responses.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("unexpected result: rdata=%02h irq=%0b tx_valid=%0b tx_byte=%02h",
                   got.rdata, got.irq, got.tx_valid, got.tx_byte);
        end
      end else begin
        exp = expected_responses.pop_front();
        if (got.rdata !== exp.rdata || got.irq !== exp.irq ||
            got.tx_valid !== exp.tx_valid || got.tx_byte !== exp.tx_byte) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("mismatch: expected rdata=%02h irq=%0b tx_valid=%0b tx_byte=%02h",
                     exp.rdata, exp.irq, exp.tx_valid, exp.tx_byte);
            $display("          actual   rdata=%02h irq=%0b tx_valid=%0b tx_byte=%02h",
                     got.rdata, got.irq, got.tx_valid, got.tx_byte);
          end
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  u16550_in_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  u16550_out_t out_data;

  uart_result_board board;
  int in_idle_pct = 25;
  int out_stall_pct = 25;
  int idle_cycles = 0;

  uart_16550_register_model dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The data byte goes to bus_wdata for bus accesses and to line_byte for
  // received line bytes; the unused field carries random bits.
  task automatic send_request(input logic [1:0] cmd, input logic [2:0] off,
                              input logic [7:0] data);
    u16550_in_t req;
    bit done;
    req.cmd = cmd;
    req.offset = off;
    req.bus_wdata = (cmd == CMD_LINE) ? 8'($urandom) : data;
    req.line_byte = (cmd == CMD_LINE) ? data : 8'($urandom);
    done = 1'b0;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    while (!done) begin
      @(posedge clk);
      done = !in_stall;
      if (done) begin
        board.note_request(req);
      end
      @(negedge clk);
    end
  endtask

  task automatic send_random_request();
    send_request(2'($urandom), 3'($urandom), 8'($urandom));
  endtask

  task automatic send_shaped_request(input traffic_t phase);
    int r;
    r = $urandom_range(99);
    case (phase)
      PHASE_FILL: begin
        if (r < 60) begin
          send_request(CMD_LINE, 3'($urandom), 8'($urandom));
        end else if (r < 70) begin
          send_request(CMD_WRITE, REG_THR, 8'($urandom));
        end else if (r < 85) begin
          send_request(CMD_READ, ($urandom_range(1) != 0) ? REG_IIR : REG_LSR, 8'($urandom));
        end else begin
          send_random_request();
        end
      end
      PHASE_DRAIN: begin
        if (r < 50) begin
          send_request(CMD_READ, REG_RBR, 8'($urandom));
        end else if (r < 65) begin
          send_request(CMD_READ, REG_LSR, 8'($urandom));
        end else if (r < 75) begin
          send_request(CMD_READ, REG_IIR, 8'($urandom));
        end else if (r < 85) begin
          send_request(CMD_LINE, 3'($urandom), 8'($urandom));
        end else begin
          send_random_request();
        end
      end
      default: send_random_request();
    endcase
  endtask

  initial begin
    int sent;
    bit quiet;
    bit [7:0] d;
    traffic_t phase;
    board = new();
    sent = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(CMD_READ, REG_IIR, 8'h00);
    send_request(CMD_READ, REG_LSR, 8'h00);
    send_request(CMD_READ, REG_RBR, 8'hFF);
    send_request(CMD_WRITE, REG_LCR, 8'h80);
    send_request(CMD_WRITE, REG_DLL, 8'hFF);
    send_request(CMD_WRITE, REG_DLM, 8'h00);
    send_request(CMD_READ, REG_DLL, 8'h00);
    send_request(CMD_READ, REG_DLM, 8'h00);
    send_request(CMD_WRITE, REG_LCR, 8'h7F);
    send_request(CMD_WRITE, REG_SCR, 8'hFF);
    send_request(CMD_WRITE, REG_IER, 8'hFF);
    send_request(CMD_WRITE, REG_MCR, 8'hFF);
    send_request(CMD_WRITE, REG_THR, 8'h00);
    send_request(CMD_LINE, REG_RBR, 8'hFF);
    send_request(CMD_WRITE, REG_THR, 8'h5A);
    send_request(CMD_READ, REG_IIR, 8'h00);
    send_request(CMD_READ, REG_RBR, 8'h00);
    send_request(CMD_WRITE, REG_MCR, 8'h08);
    send_request(CMD_WRITE, REG_THR, 8'hFF);
    send_request(CMD_LINE, REG_SCR, 8'h00);
    send_request(CMD_LINE, REG_SCR, 8'hAB);
    send_request(CMD_READ, REG_LSR, 8'h00);
    send_request(CMD_WRITE, REG_LSR, 8'hFF);
    send_request(CMD_WRITE, REG_MSR, 8'hFF);
    send_request(CMD_READ, REG_MSR, 8'h00);
    send_request(CMD_NOP, REG_SCR, 8'hFF);
    send_request(CMD_WRITE, REG_FCR, 8'hC7);
    send_request(CMD_READ, REG_IIR, 8'h00);

    while (sent < RANDOM_REQUESTS) begin
      quiet = (sent >= 600) && (sent < 900);
      in_idle_pct = quiet ? 0 : 25;
      out_stall_pct = quiet ? 0 : 25;
      phase = traffic_t'($urandom_range(2));
      if ($urandom_range(99) < 60) begin
        d = 8'($urandom);
        d[FCR_ENABLE_BIT] = ($urandom_range(99) < 85);
        send_request(CMD_WRITE, REG_FCR, d);
        d = 8'($urandom);
        d[MCR_LOOP_BIT] = ($urandom_range(99) < 20);
        send_request(CMD_WRITE, REG_MCR, d);
        d = 8'($urandom);
        d[LCR_DLAB_BIT] = ($urandom_range(99) < 10);
        send_request(CMD_WRITE, REG_LCR, d);
        send_request(CMD_WRITE, REG_IER, 8'($urandom));
        sent += 4;
      end
      repeat (30) begin
        send_shaped_request(phase);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (board.expected_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (board.failures == 0 && board.expected_responses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/u16550_pkg.sv
hdl/u16550_ram.sv
hdl/uart_16550_register_model.sv
sim/tb_top.sv
